// ----- rtl/clpe_pkg.sv -----
// Shared types, request and status codes for the circular list position engine.
package clpe_pkg;

    // Fixed field widths of the transaction payloads
    localparam int POS_W       = 16;
    localparam int DATA_IO_W   = 32;
    localparam int COUNT_OUT_W = 5;
    // Widest cell index for the largest supported depth (256 cells)
    localparam int IDX_W       = 8;

    // Request codes
    localparam logic [1:0] REQ_GET    = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_ROTATE = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Cell operation codes
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_ROT  = 2'd1;
    localparam logic [1:0] CELL_INS  = 2'd2;
    localparam logic [1:0] CELL_REM  = 2'd3;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [POS_W-1:0]     position;
        logic [DATA_IO_W-1:0] data_in;
        logic                 rotate_dir;
        logic [POS_W-1:0]     rotate_units;
    } t_req;

    typedef struct packed {
        logic [DATA_IO_W-1:0]   data_out;
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] count_out;
    } t_rsp;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] last;
    } t_cell_ctrl;

endpackage

// ----- rtl/clpe_cell.sv -----
// One storage cell of the list chain: holds one word and takes from its neighbours.
module clpe_cell #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  clpe_pkg::t_cell_ctrl  i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic [DATA_WIDTH-1:0] i_head,
    input  logic [DATA_WIDTH-1:0] i_din,
    output logic [DATA_WIDTH-1:0] o_value
);
    import clpe_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] r_value;
    logic [DATA_WIDTH-1:0] n_value;
    logic [IW-1:0]         w_idx;
    logic [IW-1:0]         w_last;

    assign w_idx  = i_ctrl.idx[IW-1:0];
    assign w_last = i_ctrl.last[IW-1:0];

    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_ROT: begin
                // advance one place towards the head, last live cell wraps to the old head
                if (MY_IDX < w_last) begin
                    n_value = i_right;
                end else if (MY_IDX == w_last) begin
                    n_value = i_head;
                end
            end
            CELL_INS: begin
                if (MY_IDX > w_idx) begin
                    n_value = i_left;
                end else if (MY_IDX == w_idx) begin
                    n_value = i_din;
                end
            end
            CELL_REM: begin
                if (MY_IDX >= w_idx) begin
                    n_value = i_right;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ----- rtl/clpe_mod.sv -----
// Bit-serial remainder unit: a 16-bit value modulo the current list count.
module clpe_mod #(
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [clpe_pkg::POS_W-1:0]       i_dividend,
    input  logic [$clog2(DEPTH+1)-1:0]       i_divisor,
    output logic                             o_done,
    output logic [$clog2(DEPTH+1)-1:0]       o_rem
);
    import clpe_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(POS_W);

    logic              r_busy;
    logic              n_busy;
    logic              r_done;
    logic              n_done;
    logic [SW-1:0]     r_cnt;
    logic [SW-1:0]     n_cnt;
    logic [POS_W-1:0]  r_dvd;
    logic [POS_W-1:0]  n_dvd;
    logic [CW-1:0]     r_div;
    logic [CW-1:0]     n_div;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     n_rem;
    logic [CW:0]       w_trial;

    assign w_trial = {r_rem, r_dvd[POS_W-1]};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_div  = r_div;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_div  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            // bring down one bit, subtract when the partial remainder reaches the divisor
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = CW'(w_trial - {1'b0, r_div});
            end else begin
                n_rem = CW'(w_trial);
            end
            n_dvd = {r_dvd[POS_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == SW'(POS_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_div <= n_div;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/circular_list_position_engine.sv -----
// Top level of the circular list position engine: sequencer, cell chain and result register.
//
// The list lives in a chain of DEPTH cells, cell 0 holding the head, and the engine serves one
// request at a time. Insert shifts the cells at and above the position one place up at once in
// the shift state, then gives its result. Remove first sweeps the ring once (one left rotation a
// cycle, picking the wanted word off the head as it passes), then closes the gap in the shift
// state. Get and rotate first reduce their 16-bit operand modulo the count in a bit-serial
// remainder unit, one bit a cycle, then get sweeps the whole ring and rotate performs its net
// number of single steps (below count), the ring moving one place per cycle. Requests on an
// empty list and inserts into a full list go straight to the result state. Results sit in an
// output register, so a new transaction is taken while the previous result still waits; the
// engine only stalls at its end until that register frees.
// count_out carries the low 5 bits of the count; data is zero-extended or truncated to 32 bits.
module circular_list_position_engine #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  clpe_pkg::t_req  i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output clpe_pkg::t_rsp  o_out
);
    import clpe_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MOD   = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [1:0]            r_type;
    logic [1:0]            n_type;
    logic                  r_dir;
    logic                  n_dir;
    logic [DATA_WIDTH-1:0] r_din;
    logic [DATA_WIDTH-1:0] n_din;
    logic [IW-1:0]         r_idx;
    logic [IW-1:0]         n_idx;
    logic [CW-1:0]         r_len;
    logic [CW-1:0]         n_len;
    logic [CW-1:0]         r_step;
    logic [CW-1:0]         n_step;
    logic                  r_capture;
    logic                  n_capture;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic [1:0]            r_status;
    logic [1:0]            n_status;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_rsp                  r_out;
    t_rsp                  n_out;

    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_cell  [DEPTH];
    logic [DATA_WIDTH-1:0] w_left  [DEPTH];
    logic [DATA_WIDTH-1:0] w_right [DEPTH];
    logic [DATA_WIDTH-1:0] w_head;
    logic                  w_mod_start;
    logic [POS_W-1:0]      w_mod_dvd;
    logic                  w_mod_done;
    logic [CW-1:0]         w_rem;
    logic [CW-1:0]         w_steps;
    logic [POS_W-1:0]      w_cnt16;
    logic [63:0]           w_din64;
    logic [63:0]           w_data64;

    // Remainder unit for get positions and rotate distances
    clpe_mod #(
        .DEPTH (DEPTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_mod_dvd),
        .i_divisor  (r_count),
        .o_done     (w_mod_done),
        .o_rem      (w_rem)
    );

    // Cell chain; the end cells see themselves where they have no neighbour
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_left[k] = w_cell[k];
        end else begin : g_inner_l
            assign w_left[k] = w_cell[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_right[k] = w_cell[k];
        end else begin : g_inner_r
            assign w_right[k] = w_cell[k+1];
        end

        clpe_cell #(
            .DEPTH      (DEPTH),
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_left  (w_left[k]),
            .i_right (w_right[k]),
            .i_head  (w_head),
            .i_din   (r_din),
            .o_value (w_cell[k])
        );
    end

    assign w_head    = w_cell[0];
    assign w_cnt16   = POS_W'(r_count);
    assign w_din64   = 64'(i_in.data_in);
    assign w_data64  = 64'(r_data);
    assign w_mod_dvd = (i_in.req_type == REQ_GET) ? i_in.position : i_in.rotate_units;

    // Net number of left single steps: backward by u is forward by count - u
    always_comb begin
        if (r_dir) begin
            w_steps = w_rem;
        end else if (w_rem == '0) begin
            w_steps = '0;
        end else begin
            w_steps = r_count - w_rem;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_type      = r_type;
        n_dir       = r_dir;
        n_din       = r_din;
        n_idx       = r_idx;
        n_len       = r_len;
        n_step      = r_step;
        n_capture   = r_capture;
        n_data      = r_data;
        n_status    = r_status;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        w_mod_start = 1'b0;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.idx  = IDX_W'(r_idx);
        w_ctrl.last = IDX_W'(r_count - 1'b1);

        // drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_type    = i_in.req_type;
                    n_dir     = i_in.rotate_dir;
                    n_din     = w_din64[DATA_WIDTH-1:0];
                    n_data    = '0;
                    n_status  = ST_OK;
                    n_capture = 1'b0;
                    n_step    = '0;
                    case (i_in.req_type)
                        REQ_INSERT: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else begin
                                // at or past the end: append
                                if (i_in.position >= w_cnt16) begin
                                    n_idx = IW'(r_count);
                                end else begin
                                    n_idx = IW'(i_in.position);
                                end
                                n_state = S_SHIFT;
                            end
                        end
                        REQ_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                // at or past the last element: take the last one
                                if (i_in.position >= w_cnt16 - 1'b1) begin
                                    n_idx = IW'(r_count - 1'b1);
                                end else begin
                                    n_idx = IW'(i_in.position);
                                end
                                n_len     = r_count;
                                n_capture = 1'b1;
                                n_state   = S_SWEEP;
                            end
                        end
                        default: begin
                            // get and rotate both need their operand modulo the count
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                w_mod_start = 1'b1;
                                n_state     = S_MOD;
                            end
                        end
                    endcase
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_step = '0;
                    if (r_type == REQ_GET) begin
                        n_idx     = IW'(w_rem);
                        n_len     = r_count;
                        n_capture = 1'b1;
                        n_state   = S_SWEEP;
                    end else if (w_steps == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_len   = w_steps;
                        n_state = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                // rotate the live cells one place; after a full sweep the ring is back in order
                w_ctrl.op = CELL_ROT;
                if (r_capture && (r_step == CW'(r_idx))) begin
                    n_data = w_head;
                end
                n_step = r_step + 1'b1;
                if (r_step == r_len - 1'b1) begin
                    n_state = (r_type == REQ_REMOVE) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_type == REQ_INSERT) begin
                    w_ctrl.op = CELL_INS;
                    n_count   = r_count + 1'b1;
                end else begin
                    w_ctrl.op = CELL_REM;
                    n_count   = r_count - 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid     = 1'b1;
                    n_out.data_out  = w_data64[DATA_IO_W-1:0];
                    n_out.status    = r_status;
                    n_out.count_out = COUNT_OUT_W'(r_count);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_type    <= n_type;
        r_dir     <= n_dir;
        r_din     <= n_din;
        r_idx     <= n_idx;
        r_len     <= n_len;
        r_step    <= n_step;
        r_capture <= n_capture;
        r_data    <= n_data;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // The list never holds more words than there are cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("list count above depth");

    // A sweep never runs past its programmed length
    a_sweep_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_step < r_len))
        else $error("sweep step beyond length");

    // Modulo and sweep only ever work on a non-empty list
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOD) || (r_state == S_SWEEP)) |-> (r_count != '0))
        else $error("modulo or sweep on empty list");

    // The remainder unit reports completion only while the sequencer waits for it
    a_mod_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> (r_state == S_MOD))
        else $error("remainder done outside modulo state");

endmodule

// ----- dv/circular_list_position_engine_tb.sv -----
// Self-checking testbench for the circular list position engine.
`timescale 1ns / 100ps

module circular_list_position_engine_tb;

    import clpe_pkg::*;

    // Shadow copy of the list: predicts each result and holds the ones still due.
    class list_shadow #(int SLOTS = 16);
        logic [DATA_IO_W-1:0] words[SLOTS];
        int unsigned          fill;
        t_rsp                 due_results[$];
        int unsigned          fail_count;

        function new();
            fill       = 0;
            fail_count = 0;
        endfunction

        function void apply_request(t_req r);
            t_rsp                 res;
            int unsigned          idx;
            int unsigned          steps;
            int unsigned          src;
            int unsigned          i;
            logic [DATA_IO_W-1:0] spun[SLOTS];
            res        = '0;
            res.status = ST_OK;
            case (r.req_type)
                REQ_GET: begin
                    if (fill == 0) res.status = ST_EMPTY;
                    else res.data_out = words[r.position % fill];
                end
                REQ_INSERT: begin
                    if (fill >= SLOTS) begin
                        res.status = ST_FULL;
                    end else begin
                        idx = (r.position >= fill) ? fill : r.position;
                        for (i = fill; i > idx; i--) words[i] = words[i-1];
                        words[idx] = r.data_in;
                        fill++;
                    end
                end
                REQ_REMOVE: begin
                    if (fill == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        idx = (r.position >= fill - 1) ? fill - 1 : r.position;
                        res.data_out = words[idx];
                        for (i = idx; i + 1 < fill; i++) words[i] = words[i+1];
                        fill--;
                    end
                end
                default: begin
                    if (fill == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        steps = r.rotate_units % fill;
                        for (i = 0; i < fill; i++) begin
                            src = r.rotate_dir ? (i + steps) % fill
                                               : (i + fill - steps) % fill;
                            spun[i] = words[src];
                        end
                        for (i = 0; i < fill; i++) words[i] = spun[i];
                    end
                end
            endcase
            res.count_out = COUNT_OUT_W'(fill);
            due_results.push_back(res);
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (due_results.size() == 0) begin
                $error("unexpected result: data_out %h status %0d count_out %0d",
                       got.data_out, got.status, got.count_out);
                fail_count++;
                return;
            end
            want = due_results.pop_front();
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
            if (got.count_out !== want.count_out) begin
                $error("count_out: expected %0d, got %0d", want.count_out, got.count_out);
                fail_count++;
            end
        endfunction
    endclass

    localparam int LIST_DEPTH   = 16;
    localparam int RANDOM_ITEMS = 1525;
    // Receiver hold-off window, in receiver cycles, to back the engine up
    localparam int HOLD_FROM    = 6000;
    localparam int HOLD_CYCLES  = 500;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic in_valid;
    logic in_ready;
    t_req in_req;
    logic out_valid;
    logic i_out_ready;
    t_rsp out_rsp;

    list_shadow #(LIST_DEPTH) shadow;

    circular_list_position_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (out_rsp)
    );

    always #4 i_clk = ~i_clk;

    // Pick a sender gap: mostly none or short, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 96) return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Pick a 16-bit operand: favour small values near the list size, keep the extremes.
    function automatic logic [POS_W-1:0] pick_operand();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return POS_W'($urandom_range(0, 65535));
            default: return POS_W'($urandom_range(0, LIST_DEPTH + 1));
        endcase
    endfunction

    function automatic t_req build_req(logic [1:0] kind, logic [POS_W-1:0] pos,
                                       logic [DATA_IO_W-1:0] word, logic dir,
                                       logic [POS_W-1:0] units);
        t_req r;
        r.req_type     = kind;
        r.position     = pos;
        r.data_in      = word;
        r.rotate_dir   = dir;
        r.rotate_units = units;
        return r;
    endfunction

    // Offer one transaction after an idle gap and hold it until the engine takes it.
    // With no gap, valid simply stays high, so it is never dropped and raised in one step.
    task automatic offer_request(input t_req r, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge i_clk); while (!in_ready);
        // Log the accepted request so its result is due from now on
        shadow.apply_request(r);
    endtask

    // Main stimulus: reset, directed corner cases, then phased random traffic
    initial begin : stimulus
        int                   n;
        int                   phase;
        int                   roll;
        logic [1:0]           kind;
        logic [DATA_IO_W-1:0] word;
        shadow   = new();
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list: every request that needs an element must report empty
        offer_request(build_req(REQ_GET,    16'hFFFF, '0, 1'b0, '0),       0);
        offer_request(build_req(REQ_REMOVE, '0,       '0, 1'b0, '0),       pick_gap());
        offer_request(build_req(REQ_ROTATE, '0,       '0, 1'b1, 16'hFFFF), pick_gap());
        // Insert at the head, append past the end, insert in the middle
        offer_request(build_req(REQ_INSERT, '0,       32'h0000_0000, 1'b0, '0), 0);
        offer_request(build_req(REQ_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '0), 0);
        offer_request(build_req(REQ_INSERT, 16'd1,    32'hA5A5_5A5A, 1'b0, '0), pick_gap());
        // Fill to the brim with random words at random places
        for (n = 0; n < LIST_DEPTH - 3; n++)
            offer_request(build_req(REQ_INSERT, pick_operand(), $urandom, 1'b0, '0),
                          pick_gap());
        // Full list: the insert is dropped and flagged, then gets, rotates and removes follow
        offer_request(build_req(REQ_INSERT, '0, 32'h1234_5678, 1'b0, '0), 0);
        offer_request(build_req(REQ_GET,    16'hFFFF, '0, 1'b0, '0),       0);
        offer_request(build_req(REQ_ROTATE, '0,       '0, 1'b0, 16'hFFFF), pick_gap());
        offer_request(build_req(REQ_ROTATE, '0,       '0, 1'b1, '0),       0);
        offer_request(build_req(REQ_GET,    '0,       '0, 1'b1, '0),       0);
        offer_request(build_req(REQ_REMOVE, 16'hFFFF, '0, 1'b0, '0),       pick_gap());
        offer_request(build_req(REQ_REMOVE, '0,       '0, 1'b1, '0),       0);

        // Random part: cycle through fill, mixed and drain phases so the list
        // keeps swinging between empty and full
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            phase = (n / 64) % 3;
            roll  = $urandom_range(0, 99);
            case (phase)
                0:       kind = (roll < 60) ? REQ_INSERT : (roll < 75) ? REQ_GET :
                                (roll < 90) ? REQ_ROTATE : REQ_REMOVE;
                1:       kind = (roll < 25) ? REQ_GET    : (roll < 50) ? REQ_INSERT :
                                (roll < 75) ? REQ_REMOVE : REQ_ROTATE;
                default: kind = (roll < 55) ? REQ_REMOVE : (roll < 70) ? REQ_GET :
                                (roll < 85) ? REQ_ROTATE : REQ_INSERT;
            endcase
            case ($urandom_range(0, 9))
                0:       word = '0;
                1:       word = '1;
                default: word = $urandom;
            endcase
            offer_request(build_req(kind, pick_operand(), word, 1'($urandom_range(0, 1)),
                                    pick_operand()),
                          pick_gap());
        end
        @(negedge i_clk);
        in_valid <= 1'b0;

        // Drain: wait for every result still due, then give stray results time to show
        while (shadow.due_results.size() != 0) @(posedge i_clk);
        repeat (48) @(posedge i_clk);

        if (shadow.fail_count == 0 && shadow.due_results.size() == 0) begin
            $display("circular_list_position_engine: match");
        end else begin
            $display("circular_list_position_engine: mismatch");
        end
        $finish;
    end

    // Receiver: runs of always-ready, random ready and long stalls, plus one long
    // hold-off so the output register fills and the engine stalls its input
    initial begin : result_sink
        int unsigned sink_cycle;
        int          run_len;
        int          pick;
        i_out_ready = 1'b0;
        sink_cycle  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            pick    = $urandom_range(0, 9);
            run_len = (pick == 9) ? $urandom_range(20, 80) : $urandom_range(1, 30);
            repeat (run_len) begin
                @(negedge i_clk);
                sink_cycle++;
                if (sink_cycle >= HOLD_FROM && sink_cycle < HOLD_FROM + HOLD_CYCLES)
                    i_out_ready <= 1'b0;
                else if (pick < 4)
                    i_out_ready <= 1'b1;
                else if (pick < 9)
                    i_out_ready <= 1'($urandom_range(0, 1));
                else
                    i_out_ready <= 1'b0;
            end
        end
    end

    // Check each result transaction as it is taken
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && i_out_ready) shadow.check_result(out_rsp);
    end

    // Watchdog: the slowest legal run stays far inside this bound
    initial begin : watchdog
        #(10_000_000);
        $display("circular_list_position_engine: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/clpe_pkg.sv
rtl/clpe_cell.sv
rtl/clpe_mod.sv
rtl/circular_list_position_engine.sv
dv/circular_list_position_engine_tb.sv
